// ----- rtl/alux_pkg.sv -----
// package for the ambient light lux calculation
// holds widths, scale constants and the segment tables; no dependencies
`default_nettype none
package alux_pkg;
  localparam int COUNT_BITS_DEF = 16;
  localparam int SCALE_FRAC = 10;
  localparam int RATIO_FRAC = 9;
  localparam int LUX_FRAC = 14;
  localparam int LUX_W = 21;
  localparam logic [20:0] LUX_MAX = 21'h1fffff;
  localparam logic [15:0] SCALE_13MS = 16'h7517;
  localparam logic [15:0] SCALE_101MS = 16'h0fe7;
  localparam logic [15:0] SCALE_UNIT = 16'h0400;
  localparam int SEG_N = 7;

  typedef enum logic [1:0] {
    IT_13MS = 2'd0,
    IT_101MS = 2'd1,
    IT_402MS = 2'd2,
    IT_MANUAL = 2'd3
  } itime_t;

  typedef enum logic [1:0] {
    REG_HIGH_GAIN = 2'd0,
    REG_ITIME = 2'd1,
    REG_PACKAGE = 2'd2
  } reg_idx_t;

  function automatic logic [9:0] brk(input logic pkg, input int seg);
    logic [9:0] r;
    r = 10'd0;
    if (!pkg) begin
      case (seg)
        0: r = 10'h040; 1: r = 10'h080; 2: r = 10'h0c0; 3: r = 10'h100;
        4: r = 10'h138; 5: r = 10'h19a; 6: r = 10'h29a; default: r = 10'd0;
      endcase
    end else begin
      case (seg)
        0: r = 10'h043; 1: r = 10'h085; 2: r = 10'h0c8; 3: r = 10'h10a;
        4: r = 10'h14d; 5: r = 10'h19a; 6: r = 10'h29a; default: r = 10'd0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [9:0] offc(input logic pkg, input logic [2:0] seg);
    logic [9:0] r;
    r = 10'd0;
    if (!pkg) begin
      case (seg)
        3'd0: r = 10'h1f2; 3'd1: r = 10'h214; 3'd2: r = 10'h23f; 3'd3: r = 10'h270;
        3'd4: r = 10'h16f; 3'd5: r = 10'h0d2; 3'd6: r = 10'h018; default: r = 10'd0;
      endcase
    end else begin
      case (seg)
        3'd0: r = 10'h204; 3'd1: r = 10'h228; 3'd2: r = 10'h253; 3'd3: r = 10'h282;
        3'd4: r = 10'h177; 3'd5: r = 10'h101; 3'd6: r = 10'h037; default: r = 10'd0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [9:0] slpc(input logic pkg, input logic [2:0] seg);
    logic [9:0] r;
    r = 10'd0;
    if (!pkg) begin
      case (seg)
        3'd0: r = 10'h1be; 3'd1: r = 10'h2d1; 3'd2: r = 10'h37b; 3'd3: r = 10'h3fe;
        3'd4: r = 10'h1fc; 3'd5: r = 10'h0fb; 3'd6: r = 10'h012; default: r = 10'd0;
      endcase
    end else begin
      case (seg)
        3'd0: r = 10'h1ad; 3'd1: r = 10'h2c1; 3'd2: r = 10'h363; 3'd3: r = 10'h3df;
        3'd4: r = 10'h1dd; 3'd5: r = 10'h127; 3'd6: r = 10'h02b; default: r = 10'd0;
      endcase
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/alux_div.sv -----
// pipelined restoring divider, one quotient bit per stage, stall via advance
// depends on alux_pkg
`default_nettype none
module alux_div import alux_pkg::*; #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 22,
  parameter int TAG_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic              in_valid,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DEN_W-1:0]  den,
  input  wire logic [TAG_W-1:0]  in_tag,
  output logic                   out_valid,
  output logic [NUM_W-1:0]       quo,
  output logic [TAG_W-1:0]       out_tag
);
  // stage k handles quotient bit NUM_W-1-k
  logic             vld [NUM_W+1];
  logic [NUM_W-1:0] nm  [NUM_W+1];
  logic [DEN_W:0]   rem [NUM_W+1];
  logic [DEN_W-1:0] dn  [NUM_W+1];
  logic [TAG_W-1:0] tg  [NUM_W+1];

  assign vld[0] = in_valid;
  assign nm[0] = num;
  assign rem[0] = '0;
  assign dn[0] = den;
  assign tg[0] = in_tag;

  for (genvar k = 0; k < NUM_W; k++) begin : g_st
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [NUM_W-1:0] nm_next;
    always_comb begin
      trial = {rem[k][DEN_W-1:0], nm[k][NUM_W-1-k]};
      ge = trial >= {1'b0, dn[k]};
      diff = trial - {1'b0, dn[k]};
      // quotient bit replaces the numerator bit just consumed
      nm_next = nm[k];
      nm_next[NUM_W-1-k] = ge;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (advance) begin
        vld[k+1] <= vld[k];
      end
      if (advance) begin
        nm[k+1] <= nm_next;
        rem[k+1] <= ge ? diff : trial;
        dn[k+1] <= dn[k];
        tg[k+1] <= tg[k];
      end
    end
  end

  assign out_valid = vld[NUM_W];
  assign quo = nm[NUM_W];
  assign out_tag = tg[NUM_W];
endmodule
`default_nettype wire

// ----- rtl/ambient_light_lux_calc.sv -----
// ambient light lux calculation, top level
// depends on alux_pkg and alux_div
//
// usage:
//   s_axis carries one transaction per sample pair: tdata[15:0] broadband
//   count, tdata[31:16] infrared count (low COUNT_BITS bits used).
//   m_axis returns one transaction per sample: tdata[20:0] lux, rest zero.
//   cfg_we/cfg_idx/cfg_data write high_gain (0), integration_time (1),
//   package_type (2); write only while the pipe is empty.
// throughput: one sample per cycle; the pipeline advances whenever the
//   output register is empty or being taken.
// pipeline: the stage 1 and stage 2 registers, the divider stages, stages 3 to 5
//   and the output register; the divider, one quotient bit per stage over the
//   shifted ir count, sets most of the depth.
// reset: clears all valid bits and loads the register reset values
//   (high_gain 0, integration_time 402 ms, package_type 0).
// stall: when m_axis_tready is low with a result held, every stage freezes
//   and s_axis_tready drops; nothing is lost or repeated.
`default_nettype none
module ambient_light_lux_calc import alux_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] broadband_count, [31:16] infrared_count
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [20:0] lux, [23:21] zero
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [1:0]  cfg_data
);
  // scaled channel width: count * scale(<=0x75170) >> 10
  localparam int CH_W = COUNT_BITS + 9;
  localparam int NUM_W = CH_W + RATIO_FRAC + 1;
  localparam int PROD_W = CH_W + 10;

  logic       high_gain;
  logic [1:0] integration_time;
  logic       package_type;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_gain <= 1'b0;
      integration_time <= IT_402MS;
      package_type <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_HIGH_GAIN: high_gain <= cfg_data[0];
        REG_ITIME:     integration_time <= cfg_data;
        REG_PACKAGE:   package_type <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // global advance: stall everything only when a held result is not taken
  logic advance;
  assign advance = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  // stage 1: select scale and multiply
  logic [19:0] scale;
  always_comb begin
    case (itime_t'(integration_time))
      IT_13MS:  scale = {4'd0, SCALE_13MS};
      IT_101MS: scale = {4'd0, SCALE_101MS};
      default:  scale = {4'd0, SCALE_UNIT};
    endcase
    if (!high_gain) scale = scale << 4;
  end

  logic                  v1;
  logic [COUNT_BITS+19:0] pbb1, pir1;
  logic                  pk1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (advance) v1 <= s_axis_tvalid;
    if (advance) begin
      pbb1 <= s_axis_tdata[COUNT_BITS-1:0] * scale;
      pir1 <= s_axis_tdata[16 +: COUNT_BITS] * scale;
      pk1 <= package_type;
    end
  end

  // stage 2: scaled channels
  logic            v2;
  logic [CH_W-1:0] ch0_2, ch1_2;
  logic            pk2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (advance) v2 <= v1;
    if (advance) begin
      ch0_2 <= pbb1[SCALE_FRAC +: CH_W];
      ch1_2 <= pir1[SCALE_FRAC +: CH_W];
      pk2 <= pk1;
    end
  end

  // divider: ratio = (ch1 << 10) / ch0; tag carries the channels
  localparam int TAG_W = 2 * CH_W + 2;
  logic             dv;
  logic [NUM_W-1:0] dq;
  logic [TAG_W-1:0] dt;
  alux_div #(.NUM_W(NUM_W), .DEN_W(CH_W), .TAG_W(TAG_W)) u_div (
    .clk(clk), .rst(rst), .advance(advance), .in_valid(v2),
    .num({ch1_2, {(RATIO_FRAC + 1){1'b0}}}), .den(ch0_2),
    .in_tag({pk2, ch0_2 == '0, ch1_2, ch0_2}),
    .out_valid(dv), .quo(dq), .out_tag(dt)
  );

  // stage 3: round ratio, pick segment
  logic [NUM_W-1:0] rr;
  logic [2:0]       seg;
  logic             segok;
  always_comb begin
    rr = dt[TAG_W-2] ? '0 : dq;
    rr = (rr + 1'b1) >> 1;
    seg = 3'd0;
    segok = 1'b0;
    for (int s = SEG_N - 1; s >= 0; s--) begin
      if (rr <= NUM_W'(brk(dt[TAG_W-1], s))) begin
        seg = 3'(s);
        segok = 1'b1;
      end
    end
  end

  logic            v3;
  logic [9:0]      b3, m3;
  logic [CH_W-1:0] ch0_3, ch1_3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (advance) v3 <= dv;
    if (advance) begin
      b3 <= segok ? offc(dt[TAG_W-1], seg) : 10'd0;
      m3 <= segok ? slpc(dt[TAG_W-1], seg) : 10'd0;
      ch0_3 <= dt[CH_W-1:0];
      ch1_3 <= dt[2*CH_W-1:CH_W];
    end
  end

  // stage 4: products
  logic              v4;
  logic [PROD_W-1:0] pos4, neg4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (advance) v4 <= v3;
    if (advance) begin
      pos4 <= ch0_3 * b3;
      neg4 <= ch1_3 * m3;
    end
  end

  // stage 5: difference with rounding, clamp at zero
  logic              v5;
  logic [PROD_W-1:0] d5;
  logic              z5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (advance) v5 <= v4;
    if (advance) begin
      z5 <= pos4 <= neg4;
      d5 <= pos4 - neg4 + PROD_W'(1 << (LUX_FRAC - 1));
    end
  end

  // output register with saturation
  logic [PROD_W-LUX_FRAC-1:0] lx;
  assign lx = d5[PROD_W-1:LUX_FRAC];
  logic [LUX_W-1:0] lux;
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (advance) m_axis_tvalid <= v5;
    if (advance) begin
      if (z5) lux <= '0;
      else if (lx > (PROD_W-LUX_FRAC)'(LUX_MAX)) lux <= LUX_MAX;
      else lux <= LUX_W'(lx);
    end
  end
  assign m_axis_tdata = {3'b000, lux};
endmodule
`default_nettype wire

// ----- rtl/alux_checker.sv -----
// port-level checker for ambient_light_lux_calc, bound to the top level
// depends on nothing but the top level's ports
`default_nettype none
module alux_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[23:21] == 3'b000)
    else $error("padding bits set");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !(m_axis_tvalid && !m_axis_tready) |-> s_axis_tready)
    else $error("input stalled while output free");
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result after reset");
endmodule

bind ambient_light_lux_calc alux_checker u_alux_checker (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// ----- tb/ambient_light_lux_calc_tb.sv -----
// testbench for the ambient light lux calculation block
// drives sample pairs over the input stream, checks lux against an in-bench predictor
// depends on alux_pkg and the ambient_light_lux_calc rtl
`timescale 1ns / 1ps
module ambient_light_lux_calc_tb;
  import alux_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [15:0] broadband_count, [31:16] infrared_count
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [20:0] lux, [23:21] zero
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = REG_HIGH_GAIN;
  logic [1:0]  cfg_data = '0;

  ambient_light_lux_calc dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // pipeline depth of the rtl for 16-bit counts; the drain wait adds a margin to it
  localparam int PIPE_DEPTH = 2 + 16 + 19 + 4;

  // predictor copy of the configuration registers
  logic       gain_hi;
  itime_t     itime;
  logic       pkg_cs;

  logic [23:0] lux_queue[$];
  int          fail_count = 0;

  // segment tables, T/FN/CL set then CS set
  logic [9:0] seg_brk[2][7] = '{
    '{10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a},
    '{10'h043, 10'h085, 10'h0c8, 10'h10a, 10'h14d, 10'h19a, 10'h29a}};
  logic [9:0] seg_off[2][7] = '{
    '{10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018},
    '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037}};
  logic [9:0] seg_slp[2][7] = '{
    '{10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012},
    '{10'h1ad, 10'h2c1, 10'h363, 10'h3df, 10'h1dd, 10'h127, 10'h02b}};

  // lux for one sample pair under the current register settings
  function automatic logic [20:0] calc_lux(logic [15:0] bb, logic [15:0] ir);
    logic [63:0] scale, ch0, ch1, ratio, pos, neg, lux, b, m;
    b = 0;
    m = 0;
    case (itime)
      IT_13MS:  scale = 64'(SCALE_13MS);
      IT_101MS: scale = 64'(SCALE_101MS);
      default:  scale = 64'd1024;   // 402 ms and manual are unscaled
    endcase
    if (!gain_hi) scale = scale << 4;
    ch0 = (64'(bb) * scale) >> 10;
    ch1 = (64'(ir) * scale) >> 10;
    ratio = (ch0 != 0) ? (ch1 << 10) / ch0 : 64'd0;  // zero broadband forces ratio 0
    ratio = (ratio + 1) >> 1;
    for (int s = 6; s >= 0; s--) begin
      if (ratio <= 64'(seg_brk[pkg_cs][s])) begin
        b = 64'(seg_off[pkg_cs][s]);
        m = 64'(seg_slp[pkg_cs][s]);
      end
    end
    pos = ch0 * b;
    neg = ch1 * m;
    // negative difference clamps to zero
    lux = (pos <= neg) ? 64'd0 : (pos - neg + 64'd8192) >> 14;
    if (lux > 64'h1fffff) lux = 64'h1fffff;
    return lux[20:0];
  endfunction

  // register write, block idle
  task automatic write_reg(reg_idx_t idx, logic [1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HIGH_GAIN: gain_hi = val[0];
      REG_ITIME:     itime = itime_t'(val);
      default:       pkg_cs = val[0];
    endcase
  endtask

  // send one sample pair; expected lux given explicitly or taken from the predictor
  // valid stays up into the next transaction when no idle cycles are drawn
  task automatic send_sample(logic [15:0] bb, logic [15:0] ir, int known_lux);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ir, bb};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (known_lux >= 0) lux_queue.push_back(24'(known_lux));
    else lux_queue.push_back({3'b000, calc_lux(bb, ir)});
  endtask

  // wait for every expected transaction, then let the pipe fully drain
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (lux_queue.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
  endtask

  // output side: random stalls per transaction, compare with oldest expectation
  initial begin
    int stall;
    logic [23:0] want;
    forever begin
      stall = $urandom_range(0, 4);
      // stretches with no stalling
      if ($urandom_range(0, 7) == 0) stall = 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      if (lux_queue.size() == 0) begin
        $error("lux: unexpected transaction, actual %0d", m_axis_tdata);
        fail_count++;
      end else begin
        want = lux_queue.pop_front();
        if (m_axis_tdata !== want) begin
          $error("lux: expected %0d actual %0d", want, m_axis_tdata);
          fail_count++;
        end
      end
    end
  end

  typedef struct {
    logic [15:0] bb;
    logic [15:0] ir;
    int          lux;   // -1: take from predictor
  } sample_row_t;

  // directed rows, run under reset settings (1x gain, 402 ms, T package)
  sample_row_t directed_rows[] = '{
    '{16'h0000, 16'h0000, 0},        // zero broadband, zero ir
    '{16'h0000, 16'hffff, 0},        // zero broadband, ratio forced to 0, negative clamps
    '{16'hffff, 16'h0000, -1},       // full broadband, no ir
    '{16'hffff, 16'hffff, -1},       // ratio 1.0, last segment
    '{16'h0001, 16'h0000, -1},
    '{16'h0100, 16'h0010, -1},       // first segment
    '{16'h1000, 16'h0200, -1},
    '{16'h1000, 16'h0300, -1},
    '{16'h1000, 16'h0500, -1},
    '{16'h1000, 16'h0700, -1},
    '{16'h1000, 16'h0900, -1},
    '{16'h1000, 16'h0c00, -1},
    '{16'h1000, 16'h1000, -1},       // ratio 1.0, last segment
    '{16'h8000, 16'h0100, -1},
    '{16'haaaa, 16'h5555, -1},
    '{16'h5555, 16'haaaa, 0},        // ratio 2.0, above last breakpoint
    '{16'h1234, 16'h0123, -1}
  };

  initial begin
    int n;
    logic [15:0] bb, ir;
    gain_hi = 1'b0;
    itime = IT_402MS;
    pkg_cs = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_sample(directed_rows[i].bb, directed_rows[i].ir, directed_rows[i].lux);
    drain();

    // sweep every setting, extremes included, with random samples in each
    for (int phase = 0; phase < 16; phase++) begin
      write_reg(REG_HIGH_GAIN, 2'(phase[0]));
      write_reg(REG_ITIME, 2'(phase[2:1]));
      write_reg(REG_PACKAGE, 2'(phase[3]));
      n = 125;
      for (int k = 0; k < n; k++) begin
        bb = 16'($urandom);
        case ($urandom_range(0, 3))
          0: ir = 16'($urandom);
          1: ir = 16'((32'(bb) * $urandom_range(0, 700)) >> 10);  // sweep all segments but the last
          2: begin
            bb = 16'($urandom_range(0, 300));
            ir = 16'($urandom_range(0, 300));
          end
          default: ir = 16'(bb >> $urandom_range(0, 8));
        endcase
        send_sample(bb, ir, -1);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // overall limit
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
